[rtl/ece_pkg.sv]
// easing curve evaluator package: constants, curve codes and pipeline records
// no dependencies
package ece_pkg;

  localparam int unsigned OUT_W = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TDATA_IN_W = 16;
  localparam int unsigned TDATA_OUT_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE    = 2'd0,
    CFG_START    = 2'd1,
    CFG_CHANGE   = 2'd2,
    CFG_DURATION = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FAM_QUAD   = 3'd0,
    FAM_CUBIC  = 3'd1,
    FAM_QUART  = 3'd2,
    FAM_QUINT  = 3'd3,
    FAM_BACK   = 3'd4,
    FAM_BOUNCE = 3'd5,
    FAM_NONE   = 3'd6
  } family_e;

  typedef enum logic [1:0] {
    FORM_IN    = 2'd0,
    FORM_OUT   = 2'd1,
    FORM_INOUT = 2'd2
  } form_e;

  typedef struct packed {
    family_e fam;
    form_e   form;
  } curve_t;

  // code = 3*family + form; each family owns three consecutive codes
  function automatic curve_t decode_curve(input logic [4:0] sel);
    curve_t     c;
    logic [4:0] base;
    c.fam  = FAM_NONE;
    c.form = FORM_IN;
    base   = 5'd0;
    if (sel inside {[5'd0:5'd2]}) begin
      c.fam = FAM_QUAD;   base = 5'd0;
    end else if (sel inside {[5'd3:5'd5]}) begin
      c.fam = FAM_CUBIC;  base = 5'd3;
    end else if (sel inside {[5'd6:5'd8]}) begin
      c.fam = FAM_QUART;  base = 5'd6;
    end else if (sel inside {[5'd9:5'd11]}) begin
      c.fam = FAM_QUINT;  base = 5'd9;
    end else if (sel inside {[5'd12:5'd14]}) begin
      c.fam = FAM_BACK;   base = 5'd12;
    end else if (sel inside {[5'd15:5'd17]}) begin
      c.fam = FAM_BOUNCE; base = 5'd15;
    end
    if (c.fam != FAM_NONE) c.form = form_e'(2'(sel - base));
    return c;
  endfunction

endpackage

[rtl/ece_divider.sv]
// pipelined restoring divider for progress = (elapsed << F) / duration
// one quotient bit per stage; no package dependency
module ece_divider #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TAG_W = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [15:0]              num_i,
  input  logic [15:0]              den_i,
  input  logic [TAG_W-1:0]         tag_i,
  output logic                     valid_o,
  output logic [FRACTION_BITS-1:0] quo_o,
  output logic [TAG_W-1:0]         tag_o
);

  // quotient fits F bits since num < den; F stages, one bit per stage
  localparam int unsigned N = FRACTION_BITS;

  logic                    vld_q [1:N];
  logic [16:0]             rem_q [1:N];
  logic [15:0]             den_q [1:N];
  logic [N-1:0]            quo_q [1:N];
  logic [TAG_W-1:0]        tag_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             vld_in;
    logic [16:0]      rem_in;
    logic [15:0]      den_in;
    logic [N-1:0]     quo_in;
    logic [TAG_W-1:0] tag_in;
    logic [17:0]      trial;
    logic             ge;
    if (k == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = {1'b0, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = vld_q[k];
      assign rem_in = rem_q[k];
      assign den_in = den_q[k];
      assign quo_in = quo_q[k];
      assign tag_in = tag_q[k];
    end
    assign trial = {rem_in, 1'b0};
    assign ge    = trial >= {2'b00, den_in};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? 17'(trial - {2'b00, den_in}) : 17'(trial);
        den_q[k+1] <= den_in;
        quo_q[k+1] <= {quo_in[N-2:0], ge};
        tag_q[k+1] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[N];
  assign quo_o   = quo_q[N];
  assign tag_o   = tag_q[N];
endmodule

[rtl/easing_curve_evaluator_top.sv]
// Easing curve evaluator. One result per accepted elapsed time; a new item can enter
// every cycle unless the output stalls. The pipeline is FRACTION_BITS stages of the
// progress divider (one quotient bit each), then decode, five curve stages, halve
// and flip, the scale by change_amount, the add of start_value and the saturating
// output register. A stall on the output freezes the whole pipeline.
// Registers are meant to be written only while no item is in flight.
// Depends on ece_pkg and ece_divider.
module easing_curve_evaluator_top #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ece_pkg::TDATA_IN_W-1:0] s_axis_tdata,   // [15:0] elapsed
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ece_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [17:0] eased_value, [18] finished
  input  logic                           cfg_we_i,
  input  logic [ece_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ece_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ece_pkg::*;

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned W = F + 4;  // signed working width, Q3.F
  localparam int unsigned NS = 9;
  localparam logic signed [W-1:0] ONE = W'(1) <<< F;
  localparam logic signed [W-1:0] TWO = W'(2) <<< F;
  localparam longint ONEL = longint'(1) << F;
  localparam logic signed [W-1:0] S_IN = W'((2 * 170158 * ONEL + 100000) / 200000);
  localparam logic signed [W-1:0] S_IO = W'((2 * 25949095 * ONEL + 10000000) / 20000000);
  localparam logic signed [W-1:0] B6 = W'((2 * 6 * ONEL + 11) / 22);
  localparam logic signed [W-1:0] B9 = W'((2 * 9 * ONEL + 11) / 22);
  localparam logic signed [W-1:0] B21 = W'((2 * 21 * ONEL + 22) / 44);
  localparam logic signed [W-1:0] L1 = W'((3 * ONEL) / 4);
  localparam logic signed [W-1:0] L2 = W'((15 * ONEL) / 16);
  localparam logic signed [W-1:0] L3 = W'((63 * ONEL) / 64);
  localparam logic signed [2*W-1:0] HALF = (2*W)'(1) <<< (F - 1);

  // configuration
  logic [4:0]         curve_q;
  logic signed [15:0] start_q, change_q;
  logic [15:0]        dur_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q  <= '0;
      start_q  <= '0;
      change_q <= '0;
      dur_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CURVE:    curve_q  <= cfg_data_i[4:0];
        CFG_START:    start_q  <= cfg_data_i;
        CFG_CHANGE:   change_q <= cfg_data_i;
        CFG_DURATION: dur_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic       in_done;
  assign in_done = s_axis_tdata[15:0] >= dur_q;

  logic           dv_valid;
  logic [F-1:0]   dv_quo;
  logic           dv_done;
  ece_divider #(.FRACTION_BITS(F), .TAG_W(1)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid && s_axis_tready),
    .num_i  (in_done ? 16'd0 : s_axis_tdata[15:0]),
    .den_i  (in_done ? 16'd1 : dur_q),
    .tag_i  (in_done),
    .valid_o(dv_valid), .quo_o(dv_quo), .tag_o(dv_done)
  );

  function automatic logic signed [W-1:0] rsh(input logic signed [2*W-1:0] v, input int n);
    logic signed [2*W-1:0] t;
    t = v + ((2*W)'(1) <<< (n - 1));
    return W'(t >>> n);
  endfunction

  function automatic logic signed [W-1:0] fm(input logic signed [W-1:0] a,
                                             input logic signed [W-1:0] b);
    logic signed [2*W-1:0] t;
    t = (2*W)'(a) * (2*W)'(b) + HALF;
    return W'(t >>> F);
  endfunction

  // per stage record
  typedef struct packed {
    logic                v;
    logic                done;
    logic [2:0]          fam;
    logic [1:0]          form;
    logic                pre;    // r = 1 - r before halving
    logic                flip;   // result = 1 - r
    logic                halve;  // halve r before flip
    logic signed [W-1:0] x;
    logic signed [W-1:0] s;
    logic signed [W-1:0] a;      // running product or back term
    logic signed [W-1:0] b;
    logic signed [W-1:0] lvl;
  } pipe_t;

  pipe_t st_q [1:NS];
  pipe_t st_d [1:NS];

  // stage 1: decode, fold form into x, set the flip and halve flags
  always_comb begin
    curve_t c;
    logic signed [W-1:0] p, q;
    logic inv;
    st_d[1] = '0;
    c = decode_curve(curve_q);
    p = W'(dv_done ? ONE : ((W)'({1'b0, dv_quo})));
    q = p <<< 1;
    st_d[1].v = dv_valid;
    st_d[1].done = dv_done;
    st_d[1].fam = c.fam;
    st_d[1].form = c.form;
    st_d[1].s = (c.form == FORM_INOUT) ? S_IO : S_IN;
    inv = 1'b0;
    case (c.form)
      FORM_IN: begin
        st_d[1].x = p; inv = 1'b0;
      end
      FORM_OUT: begin
        st_d[1].x = ONE - p; inv = 1'b1;
      end
      FORM_INOUT: begin
        st_d[1].halve = 1'b1;
        if (q < ONE) begin
          st_d[1].x = q; inv = 1'b0;
        end else begin
          st_d[1].x = TWO - q; inv = 1'b1;
        end
      end
      default: st_d[1].x = p;
    endcase
    // bounce in(x) = 1 - bounce_out(1 - x), applied before halving;
    // out form is bounce_out(p) directly
    if (c.fam == FAM_BOUNCE) begin
      if (c.form == FORM_OUT) begin
        st_d[1].x = p;
        inv = 1'b0;
      end else begin
        st_d[1].x = ONE - st_d[1].x;
        st_d[1].pre = 1'b1;
      end
    end
    st_d[1].flip = inv;
    st_d[1].a = st_d[1].x;
  end

  // stages 2..6: curve core
  for (genvar k = 2; k <= 6; k++) begin : g_core
    always_comb begin
      logic signed [W-1:0] u;
      logic signed [W+3:0] x11;
      st_d[k] = st_q[k-1];
      u = '0;
      x11 = '0;
      case (family_e'(st_q[k-1].fam))
        FAM_QUAD, FAM_CUBIC, FAM_QUART, FAM_QUINT: begin
          if (k - 2 <= int'(st_q[k-1].fam)) st_d[k].a = fm(st_q[k-1].a, st_q[k-1].x);
        end
        FAM_BACK: begin
          if (k == 2) begin
            st_d[k].a = fm(st_q[k-1].x, st_q[k-1].x);
            st_d[k].b = fm(st_q[k-1].s + ONE, st_q[k-1].x) - st_q[k-1].s;
          end else if (k == 3) begin
            st_d[k].a = fm(st_q[k-1].a, st_q[k-1].b);
          end
        end
        FAM_BOUNCE: begin
          if (k == 2) begin
            x11 = (W+4)'(st_q[k-1].x) * (W+4)'(11);
            if (x11 < ((W+4)'(4) <<< F)) begin
              u = st_q[k-1].x; st_d[k].lvl = '0;
            end else if (x11 < ((W+4)'(8) <<< F)) begin
              u = st_q[k-1].x - B6; st_d[k].lvl = L1;
            end else if (x11 < ((W+4)'(10) <<< F)) begin
              u = st_q[k-1].x - B9; st_d[k].lvl = L2;
            end else begin
              u = st_q[k-1].x - B21; st_d[k].lvl = L3;
            end
            st_d[k].b = u;
          end else if (k == 3) begin
            // 11*u stays below 4.0, so (11*u)^2 gives 121*u*u exactly
            st_d[k].b = W'((W+4)'(st_q[k-1].b) * (W+4)'(11));
          end else if (k == 4) begin
            st_d[k].a = rsh((2*W)'(st_q[k-1].b) * (2*W)'(st_q[k-1].b), F + 4) +
                        st_q[k-1].lvl;
          end
        end
        default: st_d[k].a = '0;
      endcase
    end
  end

  // stage 7: pre-invert, halve and flip; FAM_NONE gives zero
  always_comb begin
    logic signed [W-1:0] r;
    st_d[7] = st_q[6];
    r = st_q[6].a;
    if (st_q[6].pre) r = ONE - r;
    if (st_q[6].halve) r = rsh((2*W)'(r), 1);
    if (st_q[6].flip) r = ONE - r;
    if (family_e'(st_q[6].fam) == FAM_NONE) r = '0;
    st_d[7].a = r;
  end

  // stage 8: change * f, kept wide in prod_q
  logic signed [W+16:0] prod_d, prod_q, sum_q;
  logic signed [W+17:0] wide_t;
  always_comb begin
    wide_t = (W+18)'(change_q) * (W+18)'(st_q[7].a) + ((W+18)'(1) <<< (F - 1));
    prod_d = (W+17)'(wide_t >>> F);
  end

  for (genvar k = 8; k <= NS; k++) begin : g_tail
    always_comb st_d[k] = st_q[k-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      sum_q  <= prod_q + (W+17)'(start_q);
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k].v <= 1'b0;
      end else if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // sum_q is aligned with st_q[9]; saturate into output register
  logic               out_v_q, out_done_q;
  logic [OUT_W-1:0]   out_val_q;
  logic [OUT_W-1:0]   sat;
  always_comb begin
    if (sum_q > (W+17)'(131071)) sat = 18'h1FFFF;
    else if (sum_q < -(W+17)'(131072)) sat = 18'h20000;
    else sat = OUT_W'(sum_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= st_q[9].v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q  <= sat;
      out_done_q <= st_q[9].done;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_done_q, out_val_q};
endmodule

[rtl/ece_checker.sv]
// port-level checks for the easing curve evaluator
// depends on ece_pkg; bound to easing_curve_evaluator_top
module ece_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ece_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
  import ece_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline frozen");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[TDATA_OUT_W-1:OUT_W+1] == '0)
    else $error("padding bits set");
endmodule

bind easing_curve_evaluator_top ece_checker u_ece_checker (.*);
